FILE: rtl/core/hfis_pkg.sv
// Package: field widths and constants for the hex float to IEEE single converter.
package hfis_pkg;
  localparam int WordW = 32;
  localparam int FracW = 24;
  localparam int ExpW  = 7;
  localparam logic [6:0] ExpBias = 7'h46;
  typedef struct packed {
    logic [31:0] word;
    logic        ovf;
    logic        unf;
  } hfis_res_t;
endpackage

FILE: rtl/core/hfis_conv.sv
// Combinational conversion of one hex float word to IEEE single with flags.
module hfis_conv import hfis_pkg::*; (
  input  logic [WordW-1:0] src,
  output hfis_res_t        res
);
  logic [FracW-1:0] frac;
  logic             sgn;
  logic [ExpW-1:0]  e;
  logic [4:0]       p;
  logic signed [10:0] biased;
  logic signed [10:0] lsh;
  logic [5:0]       s;
  logic [47:0]      ext;
  logic [23:0]      q;
  logic [23:0]      rem_mask;
  logic [23:0]      rem;
  logic [23:0]      half;
  logic [23:0]      qr;
  logic [23:0]      mant;

  assign frac = src[FracW-1:0];
  assign sgn  = src[31];
  assign e    = src[30:24];

  always_comb begin
    p = 5'd0;
    for (int i = 0; i < FracW; i++) begin
      if (frac[i]) p = 5'(i);
    end
  end

  always_comb begin
    biased   = 11'(signed'({6'd0, p})) + 11'sd4 * (11'(signed'({4'd0, e})) - 11'sd70) + 11'sd127;
    lsh      = 11'sd4 * 11'(signed'({4'd0, e})) - 11'sd131;
    mant     = frac << (5'd23 - p);
    s        = (lsh < 0) ? ((-lsh > 11'sd31) ? 6'd32 : 6'(-lsh)) : 6'd0;
    ext      = {24'd0, frac};
    q        = (s >= 6'd24) ? 24'd0 : 24'(ext >> s);
    rem_mask = (s >= 6'd24) ? 24'hffffff : 24'((25'd1 << s) - 25'd1);
    rem      = frac & rem_mask;
    half     = (s == 6'd0 || s > 6'd24) ? 24'd0 : 24'(25'd1 << (s - 6'd1));
    qr       = q;
    res.word = 32'd0;
    res.ovf  = 1'b0;
    res.unf  = 1'b0;
    if (frac != '0) begin
      if (biased >= 11'sd255) begin
        res.word = {sgn, 31'h7f800000};
        res.ovf  = 1'b1;
      end else if (biased >= 11'sd1) begin
        res.word = {sgn, biased[7:0], mant[22:0]};
      end else if (lsh >= 0) begin
        res.word = {sgn, 31'(frac << lsh[4:0])};
      end else if (s >= 6'd32) begin
        res.word = {sgn, 31'd0};
        res.unf  = 1'b1;
      end else begin
        // s in 25..31 leaves rem = frac and half = 0; the s <= 24 guard blocks a round up
        if (rem != '0) res.unf = 1'b1;
        if (s <= 6'd24 && (rem > half || (rem == half && q[0]))) qr = q + 24'd1;
        res.word = {sgn, 7'd0, qr};
      end
    end
  end
endmodule

FILE: rtl/core/hex_float_to_ieee_single_top.sv
// Top level: registered hex float to IEEE single converter.
// One word in per cycle: an accepted in_source_word passes through the input
// register, the conversion and the result register, and its result is marked by
// out_valid for one cycle. busy stays low, so start may be held every cycle;
// the receiver cannot stall and must take each result as it appears.
module hex_float_to_ieee_single_top import hfis_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [WordW-1:0] in_source_word,
  output logic             out_valid,
  output logic [31:0]      out_ieee_word,
  output logic             out_overflow_flag,
  output logic             out_underflow_flag
);
  logic [WordW-1:0] src_r;
  logic             v1_r, v2_r;
  hfis_res_t        res_nxt, res_r;

  assign busy = 1'b0;

  hfis_conv u_conv (.src(src_r), .res(res_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
    src_r <= in_source_word;
    res_r <= res_nxt;
  end

  assign out_valid          = v2_r;
  assign out_ieee_word      = res_r.word;
  assign out_overflow_flag  = res_r.ovf;
  assign out_underflow_flag = res_r.unf;
endmodule

FILE: dv/hex_float_to_ieee_single_chk.sv
// Checker: predicts the IEEE single conversion of each accepted beat and compares results.
`timescale 1ns / 100ps
module hex_float_to_ieee_single_chk import hfis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_source_word,
  input  logic        out_valid,
  input  logic [31:0] out_ieee_word,
  input  logic        out_overflow_flag,
  input  logic        out_underflow_flag,
  output int          fail_count,
  output int          pending
);

  hfis_res_t conv_q[$];

  function automatic hfis_res_t convert_word(logic [31:0] w);
    hfis_res_t r;
    logic [23:0] frac;
    logic [31:0] sgn;
    int lead, expo, biased, lsh, s;
    logic [31:0] q, rem, half;
    frac = w[23:0];
    sgn = {w[31], 31'b0};
    expo = int'(w[30:24]);
    r = '0;
    lead = 0;
    if (frac != 0) begin
      for (int i = 0; i < 24; i++) if (frac[i]) lead = i;
      biased = lead + 4 * (expo - int'(ExpBias)) + 127;
      if (biased >= 255) begin
        r.word = sgn | 32'h7f80_0000;
        r.ovf = 1'b1;
      end else if (biased >= 1) begin
        q = {8'b0, frac} << (23 - lead);
        r.word = sgn | (32'(biased) << 23) | (q & 32'h007f_ffff);
      end else begin
        lsh = 4 * expo - 131;
        if (lsh >= 0) begin
          r.word = sgn | ({8'b0, frac} << lsh);
        end else begin
          s = -lsh;
          if (s >= 32) begin
            r.word = sgn;
            r.unf = 1'b1;
          end else begin
            q = {8'b0, frac} >> s;
            rem = {8'b0, frac} & ((32'd1 << s) - 32'd1);
            half = 32'd1 << (s - 1);
            if (rem != 0) r.unf = 1'b1;
            if (rem > half || (rem == half && q[0])) q = q + 1;
            r.word = sgn | q;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hfis_res_t want;
    int        nerr;
    nerr = 0;
    if (rst_n && start && !busy) conv_q.push_back(convert_word(in_source_word));
    if (rst_n && out_valid) begin
      if (conv_q.size() == 0) begin
        $error("result beat with nothing expected: word %h", out_ieee_word);
        nerr = nerr + 1;
      end else begin
        want = conv_q.pop_front();
        if (want.word !== out_ieee_word) begin
          $error("ieee_word exp %h got %h", want.word, out_ieee_word);
          nerr = nerr + 1;
        end
        if (want.ovf !== out_overflow_flag) begin
          $error("overflow_flag exp %b got %b", want.ovf, out_overflow_flag);
          nerr = nerr + 1;
        end
        if (want.unf !== out_underflow_flag) begin
          $error("underflow_flag exp %b got %b", want.unf, out_underflow_flag);
          nerr = nerr + 1;
        end
      end
    end
    if (nerr != 0) fail_count <= fail_count + nerr;
    pending = conv_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

FILE: dv/hex_float_to_ieee_single_top_tb.sv
// Testbench top: drives hex float beats into the converter and reports the verdict.
`timescale 1ns / 100ps
module hex_float_to_ieee_single_top_tb;
  import hfis_pkg::*;

  localparam int NumRandom = 930;
  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_source_word = '0;
  logic        busy, out_valid, out_overflow_flag, out_underflow_flag;
  logic [31:0] out_ieee_word;
  int          fail_count, pending;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  hex_float_to_ieee_single_top DUT (.*);
  hex_float_to_ieee_single_chk u_chk (.*);

  // Watchdog: cycles with neither an input nor a result beat.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("hex_float_to_ieee_single_top regression: fail");
      $finish;
    end
  end

  // One beat; start stays high across back-to-back beats.
  task automatic send_word(logic [31:0] w, int gap);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_source_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    logic [23:0] frac;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: ; // raw word, mostly normal
      // tiny exponents: subnormal, rounding and flush region
      1: w[30:24] = 7'($urandom_range(0, 36));
      // around the top of the range
      2: w[30:24] = 7'($urandom_range(90, 127));
      // unnormalized fraction
      3: w[23:0] = w[23:0] >> $urandom_range(1, 23);
      // sparse fraction for round-to-even ties
      4: begin
        frac = 24'd1 << $urandom_range(0, 23);
        if ($urandom_range(0, 1)) frac = frac | (24'd1 << $urandom_range(0, 23));
        w[23:0] = frac;
        w[30:24] = 7'($urandom_range(20, 36));
      end
      default: if ($urandom_range(0, 3) == 0) w[23:0] = '0;
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7f00_0000, 32'hff00_0000,
                 32'h41ff_ffff, 32'hc100_0001, 32'h7fff_ffff, 32'hffff_ffff,
                 32'h6100_0001, 32'h6080_0000, // overflow edge
                 32'h2110_0000, 32'h2100_0001, // exact subnormals, unnormalized
                 32'h2000_0100, 32'h20ff_ffff, // exact and rounded subnormals
                 32'h2000_0001, 32'h9c00_0003, // rounded subnormals
                 32'h1c00_0008, 32'h1c00_0018, // subnormals that round to zero
                 32'h20ff_ffff, 32'h1dff_ffff, // round up toward smallest normal
                 32'h0000_0001, 32'h80ff_ffff, // flush to zero
                 32'h1800_0080, 32'h4000_0001};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i], 0);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (n % 150 < 40) send_word(pick_word(), 0);
      else send_word(pick_word(), $urandom_range(0, 11));
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("hex_float_to_ieee_single_top regression: pass");
    else
      $display("hex_float_to_ieee_single_top regression: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/hfis_pkg.sv
rtl/core/hfis_conv.sv
rtl/core/hex_float_to_ieee_single_top.sv
dv/hex_float_to_ieee_single_chk.sv
dv/hex_float_to_ieee_single_top_tb.sv
